FILE: sv/mvd_pkg.sv
package mvd_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int NCELLS      = 16;
  localparam int LOG_N       = $clog2(NCELLS);
  localparam int ROWS        = (MAX_ENTRIES + NCELLS - 1) / NCELLS;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [12:0] SKIN_WIDTH_RESET = 13'd320;
  localparam logic        REG_SKIN_WIDTH   = 1'b0;

  typedef struct packed {
    logic [15:0] src;
    logic [12:0] s;
    logic [11:0] t;
  } query_t;

  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic             found;
    logic [IDX_W-1:0] hit;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [LOG_N-1:0] col;
    logic [ROW_W-1:0] row;
    query_t           data;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

FILE: sv/mesh_vertex_dedup.sv
// Each accepted corner is compared with the table by issuing its rows of 16 entries, one
// after another, down a chain of 16 cells; with an empty table no row is issued.
// The block takes one corner at a time: the next is accepted only once the last is done.
// Results wait in an output register; a stalled result holds the next corner back.
// Reset clears the entry count and sets skin_width to 320; entry storage is not cleared.
module mesh_vertex_dedup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_source_vertex,
  input  logic [11:0] in_tex_s,
  input  logic [11:0] in_tex_t,
  input  logic        in_on_seam,
  input  logic        in_faces_front,
  input  logic        in_last_corner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_unique_index,
  output logic        out_is_new,
  output logic [15:0] out_entry_source,
  output logic [12:0] out_entry_s,
  output logic [11:0] out_entry_t,
  output logic        out_table_full,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = mvd_pkg::CNT_W;

  mvd_pkg::state_t              state_r, state_nxt;
  mvd_pkg::query_t              query_r, query_nxt;
  logic                         last_r;
  logic [12:0]                  skin_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                rows_r, rows_calc;
  logic [CW-1:0]                issue_r;
  logic [CW-1:0]                retire_r;
  logic                         hit_found_r;
  logic [mvd_pkg::IDX_W-1:0]    hit_idx_r;
  logic                         out_valid_r;
  logic [11:0]                  out_index_r;
  logic                         out_new_r;
  mvd_pkg::query_t              out_data_r;
  logic                         out_full_r;
  logic                         in_acc;
  logic                         out_free;
  logic                         issue;
  logic                         done_go;
  logic                         has_room;
  logic                         cfg_wr;
  mvd_pkg::wr_t                 wr;
  mvd_pkg::tok_t                tok_link [mvd_pkg::NCELLS+1];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == mvd_pkg::REG_SKIN_WIDTH) ? {19'd0, skin_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skin_r <= mvd_pkg::SKIN_WIDTH_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == mvd_pkg::REG_SKIN_WIDTH)) begin
      skin_r <= cfg_pwdata[12:0];
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rows_calc = (count_r + CW'(mvd_pkg::NCELLS - 1)) >> mvd_pkg::LOG_N;
  assign has_room  = count_r < CW'(mvd_pkg::MAX_ENTRIES);

  always_comb begin
    query_nxt.src = in_source_vertex;
    query_nxt.t   = in_tex_t;
    query_nxt.s   = {1'b0, in_tex_s};
    if (!in_faces_front && in_on_seam) begin
      query_nxt.s = {1'b0, in_tex_s} + {1'b0, skin_r[12:1]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (rows_calc == '0) ? mvd_pkg::ST_DONE : mvd_pkg::ST_SCAN;
        end
      end
      mvd_pkg::ST_SCAN: begin
        if (issue_r == rows_r - CW'(1)) begin
          state_nxt = mvd_pkg::ST_DRAIN;
        end
      end
      mvd_pkg::ST_DRAIN: begin
        if (retire_r == rows_r) begin
          state_nxt = mvd_pkg::ST_DONE;
        end
      end
      mvd_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mvd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mvd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    done_go  = 1'b0;
    unique case (state_r)
      mvd_pkg::ST_IDLE:  in_stall = 1'b0;
      mvd_pkg::ST_SCAN:  issue    = 1'b1;
      mvd_pkg::ST_DRAIN: issue    = 1'b0;
      mvd_pkg::ST_DONE:  done_go  = out_free;
      default:           in_stall = 1'b1;
    endcase
  end

  always_comb begin
    tok_link[0].vld   = issue;
    tok_link[0].row   = mvd_pkg::ROW_W'(issue_r);
    tok_link[0].found = 1'b0;
    tok_link[0].hit   = '0;
  end

  always_comb begin
    wr.en   = done_go && !hit_found_r && has_room;
    wr.col  = count_r[mvd_pkg::LOG_N-1:0];
    wr.row  = mvd_pkg::ROW_W'(count_r >> mvd_pkg::LOG_N);
    wr.data = query_r;
  end

  for (genvar g = 0; g < mvd_pkg::NCELLS; g++) begin : g_cell
    mvd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (mvd_pkg::LOG_N'(g)),
      .query   (query_r),
      .count   (count_r),
      .wr      (wr),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (done_go) begin
      if (last_r) begin
        count_nxt = '0;
      end else if (!hit_found_r && has_room) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvd_pkg::ST_IDLE;
      count_r     <= '0;
      hit_found_r <= 1'b0;
      out_valid_r <= 1'b0;
      issue_r     <= '0;
      retire_r    <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (in_acc) begin
        issue_r     <= '0;
        retire_r    <= '0;
        hit_found_r <= 1'b0;
      end else begin
        if (issue) begin
          issue_r <= issue_r + CW'(1);
        end
        if (tok_link[mvd_pkg::NCELLS].vld) begin
          retire_r <= retire_r + CW'(1);
          if (tok_link[mvd_pkg::NCELLS].found && !hit_found_r) begin
            hit_found_r <= 1'b1;
          end
        end
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_r <= query_nxt;
      last_r  <= in_last_corner;
      rows_r  <= rows_calc;
    end
    if (tok_link[mvd_pkg::NCELLS].vld && tok_link[mvd_pkg::NCELLS].found && !hit_found_r) begin
      hit_idx_r <= tok_link[mvd_pkg::NCELLS].hit;
    end
    if (done_go) begin
      if (hit_found_r) begin
        out_index_r <= 12'(hit_idx_r);
        out_new_r   <= 1'b0;
        out_data_r  <= query_r;
        out_full_r  <= 1'b0;
      end else if (has_room) begin
        out_index_r <= 12'(count_r);
        out_new_r   <= 1'b1;
        out_data_r  <= query_r;
        out_full_r  <= 1'b0;
      end else begin
        out_index_r <= '0;
        out_new_r   <= 1'b0;
        out_data_r  <= '0;
        out_full_r  <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_unique_index = out_index_r;
  assign out_is_new       = out_new_r;
  assign out_entry_source = out_data_r.src;
  assign out_entry_s      = out_data_r.s;
  assign out_entry_t      = out_data_r.t;
  assign out_table_full   = out_full_r;

`ifndef SYNTHESIS
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mvd_pkg::ST_SCAN) |-> (issue_r < rows_r))
    else $error("row issued beyond the rows in use");

  a_retire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mvd_pkg::ST_IDLE) |-> (retire_r <= rows_r))
    else $error("more rows retired than issued");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(mvd_pkg::MAX_ENTRIES))
    else $error("entry count exceeds table size");

  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (done_go && !hit_found_r && has_room && !last_r) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance the entry count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mvd_pkg::ST_DONE && hit_found_r) |-> (CW'(hit_idx_r) < count_r))
    else $error("hit index outside the filled table");
`endif

endmodule

FILE: sv/mvd_cell.sv
module mvd_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [mvd_pkg::LOG_N-1:0] cell_id,
  input  mvd_pkg::query_t          query,
  input  logic [mvd_pkg::CNT_W-1:0] count,
  input  mvd_pkg::wr_t             wr,
  input  mvd_pkg::tok_t            tok_in,
  output mvd_pkg::tok_t            tok_out
);

  mvd_pkg::query_t                 bank [mvd_pkg::ROWS];
  mvd_pkg::query_t                 rdata_r;
  mvd_pkg::tok_t                   tok_r;
  logic [mvd_pkg::CNT_W-1:0]       idx;
  logic                            match;

  // Each cell owns every entry whose index has this cell's number in its low bits.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.col == cell_id)) begin
      bank[wr.row] <= wr.data;
    end
    rdata_r <= bank[tok_in.row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_in.vld;
    end
    tok_r.row   <= tok_in.row;
    tok_r.found <= tok_in.found;
    tok_r.hit   <= tok_in.hit;
  end

  always_comb begin
    idx   = (mvd_pkg::CNT_W'(tok_r.row) << mvd_pkg::LOG_N) | mvd_pkg::CNT_W'(cell_id);
    match = tok_r.vld && !tok_r.found && (idx < count) && (rdata_r == query);
    tok_out = tok_r;
    if (match) begin
      tok_out.found = 1'b1;
      tok_out.hit   = mvd_pkg::IDX_W'(idx);
    end
  end

endmodule

FILE: test/tb.sv
module tb;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STUCK_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 40;
  localparam logic [2:0] ADDR_SKIN_WIDTH = {mvd_pkg::REG_SKIN_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct packed {
    logic [15:0] src;
    logic [11:0] s;
    logic [11:0] t;
    logic        seam;
    logic        front;
    logic        last;
  } corner_t;

  typedef struct packed {
    logic [11:0] index;
    logic        is_new;
    logic [15:0] src;
    logic [12:0] s;
    logic [11:0] t;
    logic        full;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_source_vertex = '0;
  logic [11:0] in_tex_s = '0;
  logic [11:0] in_tex_t = '0;
  logic        in_on_seam = 1'b0;
  logic        in_faces_front = 1'b0;
  logic        in_last_corner = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_unique_index;
  logic        out_is_new;
  logic [15:0] out_entry_source;
  logic [12:0] out_entry_s;
  logic [11:0] out_entry_t;
  logic        out_table_full;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mesh_vertex_dedup dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  corner_t     corners_to_send[$];
  lookup_t     index_due[$];
  logic [12:0] skin_width = mvd_pkg::SKIN_WIDTH_RESET;
  int unsigned slot_of[logic [40:0]];
  int unsigned slots_used = 0;
  bit          calm = 1'b0;
  int          holdoff_at = -1;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cfg_errors = 0;
  int          corners_sent = 0;
  int          new_entries = 0;
  int          full_hits = 0;
  int          seam_shifts = 0;

  function automatic lookup_t dedup_corner(input corner_t c);
    lookup_t     r;
    logic [12:0] s_adj;
    logic [40:0] key;
    r = '0;
    s_adj = {1'b0, c.s};
    if (c.seam && !c.front) begin
      s_adj = s_adj + {1'b0, skin_width[12:1]};
      seam_shifts++;
    end
    key = {c.src, s_adj, c.t};
    if (slot_of.exists(key)) begin
      r.index = 12'(slot_of[key]);
      r.src = c.src;
      r.s = s_adj;
      r.t = c.t;
    end else if (slots_used < mvd_pkg::MAX_ENTRIES) begin
      slot_of[key] = slots_used;
      r.index = 12'(slots_used);
      r.is_new = 1'b1;
      r.src = c.src;
      r.s = s_adj;
      r.t = c.t;
      slots_used++;
      new_entries++;
    end else begin
      r.full = 1'b1;
      full_hits++;
    end
    if (c.last) begin
      slot_of.delete();
      slots_used = 0;
    end
    return r;
  endfunction

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_corner(input logic [15:0] src, input logic [11:0] s,
                                       input logic [11:0] t, input logic seam,
                                       input logic front, input logic last);
    corners_to_send.push_back('{src, s, t, seam, front, last});
  endfunction

  int gap_left = 0;
  always @(posedge clk) begin
    corner_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        index_due.push_back(dedup_corner({in_source_vertex, in_tex_s, in_tex_t, in_on_seam,
                                          in_faces_front, in_last_corner}));
        corners_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (corners_to_send.size() > 0) begin
          c = corners_to_send.pop_front();
          in_source_vertex <= c.src;
          in_tex_s <= c.s;
          in_tex_t <= c.t;
          in_on_seam <= c.seam;
          in_faces_front <= c.front;
          in_last_corner <= c.last;
          in_valid <= 1'b1;
          gap_left = idle_span();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int  stall_left = 0;
  int  hold_left = 0;
  bit  held_off = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_off && results_seen == holdoff_at) begin
      held_off = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_span();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_unique_index, out_is_new, out_entry_source, out_entry_s, out_entry_t,
             out_table_full};
      results_seen <= results_seen + 1;
      if (index_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: %p", $time, got);
      end else begin
        want = index_due.pop_front();
        if (got.index !== want.index || got.is_new !== want.is_new ||
            got.src !== want.src || got.s !== want.s || got.t !== want.t ||
            got.full !== want.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d at %0t: expected %p, got %p", results_seen, $time, want, got);
        end
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("no request moved for %0d cycles", STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (corners_to_send.size() != 0 || in_valid || index_due.size() != 0);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_SKIN_WIDTH) skin_width = value[12:0];
    @(negedge clk);
  endtask

  task automatic reg_check();
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_SKIN_WIDTH;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    if (cfg_prdata !== {19'd0, skin_width}) begin
      cfg_errors++;
      $display("skin_width read: expected %0d, got %0d", skin_width, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_meshes(input int count);
    corner_t pool[$];
    corner_t c;
    int      len;
    while (count > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      if (len > count) len = count;
      pool.delete();
      repeat ($urandom_range(1, 12)) pool.push_back(corner_t'(43'({$urandom(), $urandom()})));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          c = corner_t'(43'({$urandom(), $urandom()}));
        end else begin
          c = pool[$urandom_range(0, pool.size() - 1)];
          c.front = 1'($urandom_range(0, 1));
          c.last = (k == len - 1);
        end
        corners_to_send.push_back(c);
      end
      count -= len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    reg_check();

    queue_corner(16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, 1'b0);
    queue_corner(16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, 1'b0);
    queue_corner(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 1'b0);
    queue_corner(16'd5, 12'd100, 12'd7, 1'b1, 1'b0, 1'b0);
    queue_corner(16'd5, 12'd100, 12'd7, 1'b1, 1'b1, 1'b0);
    queue_corner(16'd5, 12'd100, 12'd7, 1'b0, 1'b0, 1'b0);
    queue_corner(16'd5, 12'd260, 12'd7, 1'b0, 1'b1, 1'b0);
    queue_corner(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 1'b0);
    queue_corner(16'h0000, 12'h000, 12'h000, 1'b1, 1'b1, 1'b1);
    queue_corner(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 1'b1);
    queue_corner(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 1'b0);
    drain();

    // A write to an unmapped register must leave skin_width alone.
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    reg_check();
    reg_write(ADDR_SKIN_WIDTH, 32'h0000_1FFF);
    reg_check();
    queue_corner(16'h1234, 12'hFFF, 12'hABC, 1'b1, 1'b0, 1'b0);
    queue_corner(16'h1234, 12'hFFF, 12'hABC, 1'b1, 1'b0, 1'b1);
    drain();

    reg_write(ADDR_SKIN_WIDTH, 32'd0);
    queue_corner(16'd7, 12'h800, 12'h001, 1'b1, 1'b0, 1'b0);
    queue_corner(16'd7, 12'h800, 12'h001, 1'b0, 1'b1, 1'b1);
    drain();

    reg_write(ADDR_SKIN_WIDTH, 32'd4096);
    reg_check();
    queue_corner(16'h00AA, 12'h7FF, 12'h555, 1'b1, 1'b0, 1'b0);
    queue_corner(16'h00AA, 12'hFFF, 12'h555, 1'b0, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: reg_write(ADDR_SKIN_WIDTH, 32'($urandom_range(0, 4096)));
        1: reg_write(ADDR_SKIN_WIDTH, 32'd1);
        2: reg_write(ADDR_SKIN_WIDTH, 32'($urandom_range(0, 8191)));
        default: reg_write(ADDR_SKIN_WIDTH, 32'(mvd_pkg::SKIN_WIDTH_RESET));
      endcase
      reg_check();
      calm = (p == 2);
      if (p == 0) holdoff_at = results_seen + 30;
      random_meshes(300);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("dedup run: %0d corners, %0d results, %0d new entries, %0d table-full lookups",
             corners_sent, results_seen, new_entries, full_hits);
    $display("seam shifts %0d over skin widths 0, 1, 320, 4096, 8191 and random; errors %0d",
             seam_shifts, mismatches + cfg_errors);
    if (mismatches == 0 && cfg_errors == 0 && index_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
